// ===== src/kdsa_pkg.sv =====
`default_nettype none
package kdsa_pkg;

    // key and field sizes
    localparam int NUM_KEYS    = 4;
    localparam int HIST_LEN    = 8;
    localparam int SP_W        = 11;
    localparam int HOLD_W      = 13;
    localparam int DELAY_W     = 12;
    localparam int PERIOD_W    = 4;
    localparam int TIER_W      = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int LED_W       = 4;

    // operation codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SETPOINT  = 3'd0,
        REG_HOLD_DELAY    = 3'd1,
        REG_REPEAT_PERIOD = 3'd2,
        REG_TIER_ONE      = 3'd3,
        REG_TIER_TWO      = 3'd4,
        REG_STEP_SMALL    = 3'd5,
        REG_STEP_MEDIUM   = 3'd6,
        REG_STEP_LARGE    = 3'd7
    } cfg_index_t;

    // register file contents
    typedef struct packed {
        logic [SP_W-1:0]     max_setpoint;
        logic [DELAY_W-1:0]  hold_delay;
        logic [PERIOD_W-1:0] repeat_period;
        logic [TIER_W-1:0]   tier_one_limit;
        logic [TIER_W-1:0]   tier_two_limit;
        logic [SP_W-1:0]     step_small;
        logic [SP_W-1:0]     step_medium;
        logic [SP_W-1:0]     step_large;
    } cfg_t;

    // auto-repeat request from one hold slot
    typedef struct packed {
        logic            fire;
        logic [SP_W-1:0] step;
    } hold_out_t;

    // step the setpoint and saturate at zero and at the limit
    function automatic logic [SP_W-1:0] sat_step(
        input logic [SP_W-1:0] sp,
        input logic [SP_W-1:0] step,
        input logic            up,
        input logic [SP_W-1:0] lim
    );
        logic [SP_W:0]   sum;
        logic [SP_W-1:0] res;
        if (up) begin
            sum = {1'b0, sp} + {1'b0, step};
        end else if (step > sp) begin
            sum = '0;
        end else begin
            sum = {1'b0, sp - step};
        end
        if (sum > {1'b0, lim}) begin
            res = lim;
        end else begin
            res = sum[SP_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/kdsa_debounce.sv =====
`default_nettype none
module kdsa_debounce (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          tick,
    input  wire logic [3:0]                    raw_keys,
    output logic      [kdsa_pkg::NUM_KEYS-1:0] level_cur,
    output logic      [kdsa_pkg::NUM_KEYS-1:0] level_next
);

    logic [kdsa_pkg::HIST_LEN-1:0] hist_reg  [kdsa_pkg::NUM_KEYS];
    logic [kdsa_pkg::HIST_LEN-1:0] hist_next [kdsa_pkg::NUM_KEYS];
    logic [kdsa_pkg::NUM_KEYS-1:0] level_reg;

    assign level_cur = level_reg;

    // shift in one sample per key, level moves only on a full run
    always_comb begin
        for (int k = 0; k < kdsa_pkg::NUM_KEYS; k++) begin
            if (k < 4) begin
                hist_next[k] = {hist_reg[k][kdsa_pkg::HIST_LEN-2:0], raw_keys[k]};
            end else begin
                hist_next[k] = {hist_reg[k][kdsa_pkg::HIST_LEN-2:0], 1'b1};
            end
            level_next[k] = level_reg[k];
            if (tick) begin
                if (hist_next[k] == '0) begin
                    level_next[k] = 1'b0;
                end else if (hist_next[k] == '1) begin
                    level_next[k] = 1'b1;
                end
            end
        end
    end

    // history and level registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < kdsa_pkg::NUM_KEYS; k++) begin
                hist_reg[k] <= '1;
            end
            level_reg <= '1;
        end else if (tick) begin
            for (int k = 0; k < kdsa_pkg::NUM_KEYS; k++) begin
                hist_reg[k] <= hist_next[k];
            end
            level_reg <= level_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/kdsa_hold.sv =====
`default_nettype none
module kdsa_hold (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               tick,
    input  wire logic               pressed,
    input  wire kdsa_pkg::cfg_t     cfg,
    output kdsa_pkg::hold_out_t     hold_out
);

    logic [kdsa_pkg::HOLD_W-1:0]   count_reg, count_next, count_inc, held_ticks;
    logic [kdsa_pkg::PERIOD_W-1:0] phase_reg, phase_next, per, ph, ph_inc;
    logic                          fire;
    logic [kdsa_pkg::SP_W-1:0]     step;

    // hold counter, tier select and repeat phase
    always_comb begin
        count_inc  = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
        held_ticks = count_inc - {1'b0, cfg.hold_delay};
        per        = (cfg.repeat_period == '0) ? kdsa_pkg::PERIOD_W'(1) : cfg.repeat_period;
        ph         = (phase_reg >= per) ? '0 : phase_reg;
        ph_inc     = ph + 1'b1;
        if (held_ticks < {1'b0, cfg.tier_one_limit}) begin
            step = cfg.step_small;
        end else if (held_ticks < {1'b0, cfg.tier_two_limit}) begin
            step = cfg.step_medium;
        end else begin
            step = cfg.step_large;
        end
        fire       = 1'b0;
        count_next = '0;
        phase_next = '0;
        if (pressed) begin
            count_next = count_inc;
            if (count_inc >= {1'b0, cfg.hold_delay}) begin
                fire       = (ph == '0);
                phase_next = (ph_inc >= per) ? '0 : ph_inc;
            end
        end
    end

    assign hold_out.fire = tick & fire;
    assign hold_out.step = step;

    // slot state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            phase_reg <= '0;
        end else if (tick) begin
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/key_debounce_setpoint_adjuster.sv =====
// Key debounce and setpoint adjuster. Each s_ item is either a scan tick carrying four
// active-low key samples or a setpoint load; each produces exactly one m_ item with the
// setpoint, the change flag, the adjust enable, the LED pin levels and the debounced keys.
// One item is taken per clock cycle while m_ready does not stall the output: an input
// register feeds the debounce, hold-counter and setpoint logic that loads the result
// register, and the item then appears on m_. Registers are written through cfg_
// (cfg_ready is always high); the user must write them only while no item is in flight,
// which the block itself does not enforce.
`default_nettype none
module key_debounce_setpoint_adjuster (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic [3:0]                        s_raw_keys,
    input  wire logic [kdsa_pkg::SP_W-1:0]         s_load_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [kdsa_pkg::SP_W-1:0]         m_setpoint,
    output logic                                   m_setpoint_changed,
    output logic                                   m_adjust_enabled,
    output logic      [kdsa_pkg::LED_W-1:0]        m_led_levels,
    output logic      [3:0]                        m_debounced_keys,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kdsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kdsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    kdsa_pkg::cfg_t            cfg_reg;
    logic                      in_valid_reg, op_reg;
    logic [3:0]                raw_reg;
    logic [kdsa_pkg::SP_W-1:0] load_reg;
    logic                      out_valid_reg;
    logic                      advance, tick;

    logic [kdsa_pkg::NUM_KEYS-1:0] level_cur, level_next;
    logic [3:0]                    new_press;
    kdsa_pkg::hold_out_t           hold_dn, hold_up;

    logic [kdsa_pkg::SP_W-1:0] sp_reg, sp_next, sp_a, sp_b, sp_c, sp_d, load_sat;
    logic                      en_reg, en_next;
    logic [1:0]                tog_reg, tog_next;
    logic                      changed;
    logic [kdsa_pkg::LED_W-1:0] leds;

    // handshakes
    assign advance   = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready   = ~in_valid_reg | advance;
    assign cfg_ready = 1'b1;
    assign tick      = advance & (op_reg == kdsa_pkg::OP_SCAN);

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_setpoint   <= kdsa_pkg::SP_W'(2047);
            cfg_reg.hold_delay     <= kdsa_pkg::DELAY_W'(300);
            cfg_reg.repeat_period  <= kdsa_pkg::PERIOD_W'(3);
            cfg_reg.tier_one_limit <= kdsa_pkg::TIER_W'(45);
            cfg_reg.tier_two_limit <= kdsa_pkg::TIER_W'(150);
            cfg_reg.step_small     <= kdsa_pkg::SP_W'(10);
            cfg_reg.step_medium    <= kdsa_pkg::SP_W'(50);
            cfg_reg.step_large     <= kdsa_pkg::SP_W'(100);
        end else if (cfg_valid) begin
            unique case (kdsa_pkg::cfg_index_t'(cfg_index))
                kdsa_pkg::REG_MAX_SETPOINT:  cfg_reg.max_setpoint   <= cfg_data[kdsa_pkg::SP_W-1:0];
                kdsa_pkg::REG_HOLD_DELAY:    cfg_reg.hold_delay     <= cfg_data[kdsa_pkg::DELAY_W-1:0];
                kdsa_pkg::REG_REPEAT_PERIOD: cfg_reg.repeat_period  <= cfg_data[kdsa_pkg::PERIOD_W-1:0];
                kdsa_pkg::REG_TIER_ONE:      cfg_reg.tier_one_limit <= cfg_data[kdsa_pkg::TIER_W-1:0];
                kdsa_pkg::REG_TIER_TWO:      cfg_reg.tier_two_limit <= cfg_data[kdsa_pkg::TIER_W-1:0];
                kdsa_pkg::REG_STEP_SMALL:    cfg_reg.step_small     <= cfg_data[kdsa_pkg::SP_W-1:0];
                kdsa_pkg::REG_STEP_MEDIUM:   cfg_reg.step_medium    <= cfg_data[kdsa_pkg::SP_W-1:0];
                kdsa_pkg::REG_STEP_LARGE:    cfg_reg.step_large     <= cfg_data[kdsa_pkg::SP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            raw_reg  <= s_raw_keys;
            load_reg <= s_load_value;
        end
    end

    // debounce and hold slots
    kdsa_debounce u_debounce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (tick),
        .raw_keys   (raw_reg),
        .level_cur  (level_cur),
        .level_next (level_next)
    );

    kdsa_hold u_hold_dn (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick     (tick),
        .pressed  (~level_next[1]),
        .cfg      (cfg_reg),
        .hold_out (hold_dn)
    );

    kdsa_hold u_hold_up (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick     (tick),
        .pressed  (~level_next[3]),
        .cfg      (cfg_reg),
        .hold_out (hold_up)
    );

    // a new press is a falling edge of the debounced level
    assign new_press = level_cur[3:0] & ~level_next[3:0];

    // key actions in key order: down press, down repeat, enable toggle, up press, up repeat
    always_comb begin
        load_sat = (load_reg > cfg_reg.max_setpoint) ? cfg_reg.max_setpoint : load_reg;
        en_next  = en_reg ^ new_press[2];
        tog_next = tog_reg ^ {new_press[2], new_press[0]};
        sp_a = (new_press[1] && en_reg)
             ? kdsa_pkg::sat_step(sp_reg, kdsa_pkg::SP_W'(1), 1'b0, cfg_reg.max_setpoint)
             : sp_reg;
        sp_b = (hold_dn.fire && en_reg)
             ? kdsa_pkg::sat_step(sp_a, hold_dn.step, 1'b0, cfg_reg.max_setpoint)
             : sp_a;
        sp_c = (new_press[3] && en_next)
             ? kdsa_pkg::sat_step(sp_b, kdsa_pkg::SP_W'(1), 1'b1, cfg_reg.max_setpoint)
             : sp_b;
        sp_d = (hold_up.fire && en_next)
             ? kdsa_pkg::sat_step(sp_c, hold_up.step, 1'b1, cfg_reg.max_setpoint)
             : sp_c;
        if (op_reg == kdsa_pkg::OP_LOAD) begin
            sp_next = load_sat;
            changed = 1'b0;
        end else begin
            sp_next = sp_d;
            changed = (en_reg & (new_press[1] | hold_dn.fire))
                    | (en_next & (new_press[3] | hold_up.fire));
        end
        leds = {level_next[3], tog_next[1], level_next[1], tog_next[0]};
    end

    // adjuster state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg  <= '0;
            en_reg  <= 1'b0;
            tog_reg <= 2'b10;
        end else if (advance) begin
            sp_reg  <= sp_next;
            en_reg  <= en_next;
            tog_reg <= tog_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= advance | (out_valid_reg & ~m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_setpoint         <= sp_next;
            m_setpoint_changed <= changed;
            m_adjust_enabled   <= en_next;
            m_led_levels       <= leds;
            m_debounced_keys   <= level_next[3:0];
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== src/kdsa_checker.sv =====
`default_nettype none
module kdsa_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [kdsa_pkg::SP_W-1:0]       m_setpoint,
    input wire logic                            m_adjust_enabled,
    input wire logic [kdsa_pkg::LED_W-1:0]      m_led_levels,
    input wire logic [3:0]                      m_debounced_keys
);

    // no item out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // a stalled item holds its setpoint
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_setpoint))
        else $error("stalled item changed");

    // hold leds follow the debounced up and down keys
    a_hold_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_led_levels[1] == m_debounced_keys[1])
                 && (m_led_levels[3] == m_debounced_keys[3]))
        else $error("hold led does not follow its key");

    // led2 lit exactly while adjust is enabled
    a_enable_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_led_levels[2] != m_adjust_enabled))
        else $error("enable led out of step with adjust enable");

endmodule

bind key_debounce_setpoint_adjuster kdsa_checker u_kdsa_checker (.*);
`default_nettype wire
